[design/deq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DeqDepth = 16;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
  } deq_ctrl_t;

endpackage

`default_nettype wire

[design/double_ended_queue_core.sv]
// channel   | transfer when      | ports
// ----------+--------------------+-------------------------------
// command   | start && !busy     | kind, value
// result    | done               | status, popped, occupancy
//
// one operation per cycle; busy stays low, the entries move one cell per cycle
// result shows in the cycle after its command, for one cycle, marked by done
// pop back reads the cell at the back through a one-hot select over the row
// synchronous reset empties the queue; entry contents are left as they are
// the receiver cannot stall, so results never back up into the command side
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = DeqDepth,
  localparam int CountW = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              kind,
  input  wire logic signed [DataW-1:0] value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [DataW-1:0]      popped,
  output logic [CountW-1:0]            occupancy
);

  logic [CountW-1:0]       count;
  logic [CountW-1:0]       count_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  deq_ctrl_t               ctrl;
  status_t                 status_next;
  logic signed [DataW-1:0] popped_next;
  logic signed [DataW-1:0] back_value;
  logic signed [DataW-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        last_sel;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CountW'(DEPTH));
  assign empty  = (count == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_in;
    logic signed [DataW-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_val[i+1];
    end
    deq_cell #(
      .Idx    (i),
      .CountW (CountW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .push_value  (value),
      .left_value  (left_in),
      .right_value (right_in),
      .cell_value  (cell_val[i]),
      .is_last     (last_sel[i])
    );
  end

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_val[i] & {DataW{last_sel[i]}});
    end
  end

  always_comb begin
    ctrl        = '0;
    status_next = ST_DONE;
    popped_next = '0;
    count_next  = count;
    case (kind_t'(kind))
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.push_front = accept;
          count_next      = count + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.push_back = accept;
          count_next     = count + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.pop_front = accept;
          popped_next    = cell_val[0];
          count_next     = count - 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          popped_next = back_value;
          count_next  = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      popped    <= popped_next;
      occupancy <= count_next;
    end
  end

endmodule

`default_nettype wire

[design/deq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int Idx = 0,
  parameter int CountW = 5
) (
  input  wire logic                    clk,
  input  wire deq_ctrl_t               ctrl,
  input  wire logic [CountW-1:0]       count,
  input  wire logic signed [DataW-1:0] push_value,
  input  wire logic signed [DataW-1:0] left_value,
  input  wire logic signed [DataW-1:0] right_value,
  output logic signed [DataW-1:0]      cell_value,
  output logic                         is_last
);

  logic signed [DataW-1:0] entry;
  logic                    at_back;

  assign at_back    = (count == CountW'(Idx));
  assign is_last    = (count == CountW'(Idx + 1));
  assign cell_value = entry;

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      entry <= left_value;
    end else if (ctrl.pop_front) begin
      entry <= right_value;
    end else if (ctrl.push_back && at_back) begin
      entry <= push_value;
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int CountW = $clog2(DeqDepth + 1);
  localparam int RandomOps = 1600;
  localparam int CalmTail = 200;
  localparam int NumRows = 25;

  typedef struct {
    status_t                   status;
    logic signed [DataW-1:0]   popped;
    logic [CountW-1:0]         occupancy;
  } outcome_t;

  typedef struct {
    bit       pinned;
    outcome_t outcome;
  } pin_t;

  typedef struct {
    kind_t                   kind;
    logic signed [DataW-1:0] value;
    bit                      pinned;
    status_t                 status;
    logic signed [DataW-1:0] popped;
    int                      occupancy;
  } cmd_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              kind = KIND_PUSH_FRONT;
  logic signed [DataW-1:0] value = '0;
  logic                    done;
  logic [1:0]              status;
  logic signed [DataW-1:0] popped;
  logic [CountW-1:0]       occupancy;

  // predictor state
  logic signed [DataW-1:0] ring_cells [DeqDepth];
  int                      front_slot = 0;
  int                      held = 0;

  outcome_t pending_results [$];
  pin_t     pinned_outcomes [$];
  int       failures = 0;
  int       transfers = 0;
  int       pops_done = 0;
  int       full_refusals = 0;
  int       empty_refusals = 0;

  cmd_row_t directed_rows [NumRows];

  double_ended_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .value     (value),
    .done      (done),
    .status    (status),
    .popped    (popped),
    .occupancy (occupancy)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic outcome_t apply_operation(kind_t op, logic signed [DataW-1:0] v);
    outcome_t res;
    int       slot;
    res.status = ST_DONE;
    res.popped = '0;
    if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
      if (held >= DeqDepth) begin
        res.status = ST_FULL;
        full_refusals++;
      end else if (op == KIND_PUSH_FRONT) begin
        front_slot = (front_slot + DeqDepth - 1) % DeqDepth;
        ring_cells[front_slot] = v;
        held++;
      end else begin
        slot = (front_slot + held) % DeqDepth;
        ring_cells[slot] = v;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
        empty_refusals++;
      end else if (op == KIND_POP_FRONT) begin
        res.popped = ring_cells[front_slot];
        front_slot = (front_slot + 1) % DeqDepth;
        held--;
        pops_done++;
      end else begin
        slot = (front_slot + held - 1) % DeqDepth;
        res.popped = ring_cells[slot];
        held--;
        pops_done++;
      end
    end
    res.occupancy = CountW'(held);
    return res;
  endfunction

  // command transfers feed the predictor, result strobes are checked in order
  always @(posedge clk) begin
    outcome_t predicted;
    outcome_t want;
    pin_t     pin;
    if (!rst) begin
      if (start && !busy) begin
        predicted = apply_operation(kind_t'(kind), value);
        pin = pinned_outcomes.pop_front();
        pending_results.push_back(pin.pinned ? pin.outcome : predicted);
        transfers++;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          if (popped !== want.popped) begin
            $error("popped: expected %0d, got %0d", want.popped, popped);
            failures++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            failures++;
          end
        end
      end
    end
  end

  task automatic send_cmd(kind_t op, logic signed [DataW-1:0] v, pin_t pin);
    pinned_outcomes.push_back(pin);
    start <= 1'b1;
    kind <= op;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_cmds(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    pin_t  pin;
    kind_t op;
    int    mode;
    int    mode_left;
    int    waited;
    int    roll;

    directed_rows = '{
      '{KIND_POP_FRONT,  32'sh0,          1'b1, ST_EMPTY, 32'sh0,          0},
      '{KIND_POP_BACK,   32'sh1234_5678,  1'b1, ST_EMPTY, 32'sh0,          0},
      '{KIND_PUSH_BACK,  32'sh7FFF_FFFF,  1'b1, ST_DONE,  32'sh0,          1},
      '{KIND_PUSH_FRONT, 32'sh8000_0000,  1'b1, ST_DONE,  32'sh0,          2},
      '{KIND_POP_BACK,   32'sh0,          1'b1, ST_DONE,  32'sh7FFF_FFFF,  1},
      '{KIND_POP_BACK,   -32'sd1,         1'b1, ST_DONE,  32'sh8000_0000,  0},
      '{KIND_PUSH_FRONT, -32'sd1,         1'b1, ST_DONE,  32'sh0,          1},
      '{KIND_POP_FRONT,  32'sh0,          1'b1, ST_DONE,  -32'sd1,         0},
      '{KIND_PUSH_BACK,  32'sh1111_0001,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'sh2222_0002,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'sh3333_0003,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'sh4444_0004,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'sh5555_0005,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'sh6666_0006,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'sh7777_0007,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'sh8888_0008,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'sh9999_0009,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'shAAAA_000A,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'shBBBB_000B,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'shCCCC_000C,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'shDDDD_000D,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'shEEEE_000E,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'shFFFF_000F,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_FRONT, 32'sh0F0F_0010,  1'b0, ST_DONE,  32'sh0,          0},
      '{KIND_PUSH_BACK,  32'sh5A5A_A5A5,  1'b1, ST_FULL,  32'sh0,         16}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pin.pinned = directed_rows[i].pinned;
      pin.outcome.status = directed_rows[i].status;
      pin.outcome.popped = directed_rows[i].popped;
      pin.outcome.occupancy = CountW'(directed_rows[i].occupancy);
      send_cmd(directed_rows[i].kind, directed_rows[i].value, pin);
    end

    // fill, drain and balanced phases so the queue keeps hitting full and empty
    pin.pinned = 1'b0;
    mode = 1;
    mode_left = 0;
    for (int n = 0; n < RandomOps; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      case (mode)
        0: op = (roll < 85) ? kind_t'($urandom_range(0, 1)) : kind_t'($urandom_range(2, 3));
        1: op = (roll < 85) ? kind_t'($urandom_range(2, 3)) : kind_t'($urandom_range(0, 1));
        default: op = kind_t'($urandom_range(0, 3));
      endcase
      send_cmd(op, pick_value(), pin);
      if (n < RandomOps - CalmTail && $urandom_range(0, 4) == 0) begin
        pause_cmds($urandom_range(1, 8));
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failures++;
    end

    $display("%0d commands transferred: %0d values popped, %0d pushes refused as full,",
             transfers, pops_done, full_refusals);
    $display("%0d pops refused as empty", empty_refusals);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
